@@ rtl/core/dtc_pkg.sv @@
// Shared types, constants and the modular reduction helper of the domino tiling counter.
// Used by dtc_front, dtc_queue, dtc_back, domino_tiling_counter_core and the bench; no dependencies.
package dtc_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned CntW  = 30;

  // The modulus and 2^30 mod the modulus, used to fold high bits back down.
  localparam logic [CntW-1:0] Prime     = 30'd1000000007;
  localparam logic [CntW-1:0] FoldK     = 30'd73741817;
  localparam logic [LenW:0]   LengthMax = 17'd65535;

  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_W3    = 2'd1,
    MODE_W4    = 2'd2,
    MODE_W5    = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [LenW-1:0]   steps;
    logic [CntW-1:0]   value;
  } cmd_t;

  // Reduces any 33-bit value modulo the prime: one fold of the top three bits,
  // which leaves less than twice the prime, then one compare and subtract.
  function automatic logic [CntW-1:0] fold33(input logic [32:0] x);
    logic [30:0] prod;
    logic [30:0] v;
    prod = 31'(x[32:30]) * 31'(FoldK);
    v    = {1'b0, x[29:0]} + prod;
    if (v >= {1'b0, Prime}) begin
      v = v - {1'b0, Prime};
    end
    return v[CntW-1:0];
  endfunction

endpackage

@@ rtl/core/dtc_front.sv @@
// Front end of the domino tiling counter: accepts a board and classifies it into a command.
// Depends on dtc_pkg.
module dtc_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               board_width_i,
  input  logic [dtc_pkg::LenW-1:0] board_length_i,
  input  logic                     queue_full_i,
  output logic                     push_o,
  output dtc_pkg::cmd_t            cmd_o
);
  import dtc_pkg::*;

  logic              odd;
  logic [LenW-2:0]   half;
  logic              bad_len;

  assign odd     = board_length_i[0];
  assign half    = board_length_i[LenW-1:1];
  assign bad_len = (board_length_i == '0) || ({1'b0, board_length_i} > LengthMax);

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    cmd_o.mode  = MODE_CONST;
    cmd_o.steps = '0;
    cmd_o.value = '0;
    if (!bad_len) begin
      unique case (board_width_i)
        3'd3: begin
          if (!odd) begin
            cmd_o.mode  = MODE_W3;
            cmd_o.steps = {1'b0, half} - 16'd1;
          end
        end
        3'd4: begin
          if (board_length_i == 16'd1) begin
            cmd_o.value = 30'd1;
          end else begin
            cmd_o.mode  = MODE_W4;
            cmd_o.steps = board_length_i - 16'd2;
          end
        end
        3'd5: begin
          if (!odd) begin
            if (half == 15'd1) begin
              cmd_o.value = 30'd8;
            end else if (half == 15'd2) begin
              cmd_o.value = 30'd95;
            end else if (half == 15'd3) begin
              cmd_o.value = 30'd1183;
            end else begin
              cmd_o.mode  = MODE_W5;
              cmd_o.steps = {1'b0, half} - 16'd3;
            end
          end
        end
        default: begin
          cmd_o.mode = MODE_CONST;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/dtc_queue.sv @@
// Two-entry command queue between the front end and the recurrence engine.
// Depends on dtc_pkg.
module dtc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dtc_pkg::cmd_t cmd_o
);
  import dtc_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/core/dtc_back.sv @@
// Recurrence engine of the domino tiling counter with its output register.
// Depends on dtc_pkg.
module dtc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  dtc_pkg::cmd_t            cmd_i,
  output logic                     cmd_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [dtc_pkg::CntW-1:0] tiling_count_o
);
  import dtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [LenW-1:0]   steps_q, steps_d;
  logic [1:0]        phase_q, phase_d;
  logic [CntW-1:0]   r_q [5];
  logic [CntW-1:0]   r_d [5];
  logic [35:0]       t_q, t_d;
  logic [CntW-1:0]   result_q, result_d;
  logic              out_valid_q, out_valid_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_free;
  logic [35:0]       s13;

  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign tiling_count_o = count_q;
  assign s13            = 36'(r_q[1]) + 36'(r_q[3]);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    steps_d     = steps_q;
    phase_d     = phase_q;
    r_d         = r_q;
    t_d         = t_q;
    result_d    = result_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          mode_d    = cmd_i.mode;
          steps_d   = cmd_i.steps;
          result_d  = cmd_i.value;
          phase_d   = 2'd0;
          case (cmd_i.mode)
            MODE_W3: begin
              r_d[0] = 30'd3;
              r_d[1] = 30'd1;
            end
            MODE_W4: begin
              r_d[0] = 30'd1;
              r_d[1] = 30'd5;
              r_d[2] = 30'd1;
              r_d[3] = 30'd0;
              r_d[4] = 30'd1;
            end
            MODE_W5: begin
              r_d[0] = 30'd1;
              r_d[1] = 30'd8;
              r_d[2] = 30'd95;
              r_d[3] = 30'd1183;
            end
            default: begin
              r_d = r_q;
            end
          endcase
          state_d = (cmd_i.mode == MODE_CONST) ? S_EMIT : S_RUN;
        end
      end

      S_RUN: begin
        if (steps_q == '0) begin
          case (mode_q)
            MODE_W3: result_d = r_q[0];
            MODE_W4: result_d = r_q[1];
            default: result_d = r_q[3];
          endcase
          state_d = S_EMIT;
        end else begin
          case (mode_q)
            MODE_W3: begin
              // g' = f + g and f' = f + 2g' = 3f + 2g.
              r_d[1]  = fold33(33'(r_q[0]) + 33'(r_q[1]));
              r_d[0]  = fold33((33'(r_q[0]) << 1) + 33'(r_q[0]) + (33'(r_q[1]) << 1));
              steps_d = steps_q - 16'd1;
            end
            MODE_W4: begin
              // The new term expands to fcur + 4 fprev + 2 g1 + g2a before reduction.
              r_d[0]  = r_q[1];
              r_d[1]  = fold33(33'(r_q[1]) + (33'(r_q[0]) << 2) + (33'(r_q[2]) << 1)
                               + 33'(r_q[3]));
              r_d[2]  = fold33(33'(r_q[0]) + 33'(r_q[2]));
              r_d[3]  = r_q[4];
              r_d[4]  = fold33(33'(r_q[0]) + 33'(r_q[3]));
              steps_d = steps_q - 16'd1;
            end
            MODE_W5: begin
              case (phase_q)
                2'd0: begin
                  // Negative terms enter as multiples of (prime - x), so the sum stays
                  // positive and below 63 times the prime.
                  t_d = (s13 << 4) - s13
                      + ((36'(Prime) - 36'(r_q[2])) << 5)
                      + (36'(Prime) - 36'(r_q[0]));
                  phase_d = 2'd1;
                end
                2'd1: begin
                  t_d     = 36'(t_q[35:30]) * 36'(FoldK) + 36'(t_q[29:0]);
                  phase_d = 2'd2;
                end
                default: begin
                  r_d[0]  = r_q[1];
                  r_d[1]  = r_q[2];
                  r_d[2]  = r_q[3];
                  r_d[3]  = fold33(t_q[32:0]);
                  steps_d = steps_q - 16'd1;
                  phase_d = 2'd0;
                end
              endcase
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          count_d     = result_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= 2'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    steps_q  <= steps_d;
    r_q      <= r_d;
    t_q      <= t_d;
    result_q <= result_d;
    count_q  <= count_d;
  end

endmodule

@@ rtl/core/domino_tiling_counter_core.sv @@
// The recurrence engine does one step per cycle for widths 3 and 4; for width 5 each step
// forms a sum below 63 times the prime, folds its top bits, then reduces the fold fully
// and shifts in the new term. Fixed answers skip the recurrence.
// Throughput: one board per engine run; a two-entry queue takes boards meanwhile.
// Reset: asynchronous, active low; clears the queue, engine state and output valid.
module domino_tiling_counter_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               board_width_i,
  input  logic [dtc_pkg::LenW-1:0] board_length_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [dtc_pkg::CntW-1:0] tiling_count_o
);
  import dtc_pkg::*;

  // Command from the classifier into the queue, and from the queue into the engine.
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic queue_full;
  logic queue_valid;
  logic pop;

  // The front end classifies each board the cycle it is offered: odd areas, zero lengths,
  // unknown widths, width-4 boards of length 1 and short width-5 boards become fixed
  // answers, everything else becomes a step count for the matching recurrence.
  dtc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .board_width_i  (board_width_i),
    .board_length_i (board_length_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .cmd_o          (front_cmd)
  );

  // The queue decouples input transfers from the long-running engine.
  dtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The engine keeps only the last few terms of the recurrence and reduces each
  // update modulo the prime; its output register lets it finish the next board's
  // answer, fixed or computed, while a result still waits for transfer.
  dtc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (queue_valid),
    .cmd_i          (queue_cmd),
    .cmd_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tiling_count_o (tiling_count_o)
  );

  // The engine only takes a command that the queue actually holds.
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> queue_valid)
    else $error("engine popped an empty queue");

  // After a board is transferred, the queue holds a command for the engine on the next cycle.
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> queue_valid)
    else $error("transferred board missing from queue");

  // Every result is fully reduced.
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tiling_count_o < Prime))
    else $error("result not reduced modulo the prime");

endmodule

@@ bench/dtc_tiling_checker.sv @@
// Checker for the domino tiling counter: watches both channels, predicts each count, compares.
// Depends on dtc_pkg for the field widths only; instantiated by tb.
module dtc_tiling_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [2:0]               board_width_i,
  input  logic [dtc_pkg::LenW-1:0] board_length_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic [dtc_pkg::CntW-1:0] tiling_count_i,
  output int                       failures_o,
  output int                       pending_o,
  output int                       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Modulus = 64'd1000000007;

  typedef struct {
    logic [2:0]               width;
    logic [dtc_pkg::LenW-1:0] length;
    logic [dtc_pkg::CntW-1:0] count;
  } board_answer_t;

  board_answer_t answers_due[$];
  int failures = 0;
  int checked  = 0;
  int pending  = 0;

  assign failures_o = failures;
  assign pending_o  = pending;
  assign checked_o  = checked;

  function automatic bit [31:0] add_mod(input bit [31:0] a, input bit [31:0] b);
    bit [32:0] s;
    s = a + b;
    if (s >= Modulus) begin
      s = s - Modulus;
    end
    return s[31:0];
  endfunction

  function automatic bit [31:0] sub_mod(input bit [31:0] a, input bit [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) begin
      d = d + Modulus;
    end
    return 32'(d);
  endfunction

  function automatic bit [31:0] scale_mod(input bit [31:0] a, input int k);
    return 32'((longint'(a) * k) % Modulus);
  endfunction

  // Width 3: two coupled terms, one step per column pair.
  function automatic bit [31:0] count_width3(input int unsigned len);
    bit [31:0] f;
    bit [31:0] g;
    int unsigned col;
    f = 3;
    g = 1;
    for (col = 4; col <= len; col += 2) begin
      g = add_mod(f, g);
      f = add_mod(f, add_mod(g, g));
    end
    return f;
  endfunction

  // Width 4: three coupled terms, one step per column.
  function automatic bit [31:0] count_width4(input int unsigned len);
    bit [31:0] f_prev, f_cur, g1, g2a, g2b, n1, n2, nf;
    int unsigned col;
    f_prev = 1;
    f_cur  = 5;
    g1     = 1;
    g2a    = 0;
    g2b    = 1;
    if (len == 1) begin
      return 1;
    end
    for (col = 3; col <= len; col++) begin
      n1     = add_mod(f_prev, g1);
      n2     = add_mod(f_prev, g2a);
      nf     = add_mod(add_mod(add_mod(f_cur, f_prev), add_mod(n1, n1)), n2);
      f_prev = f_cur;
      f_cur  = nf;
      g1     = n1;
      g2a    = g2b;
      g2b    = n2;
    end
    return f_cur;
  endfunction

  // Width 5: order-four recurrence over column pairs, seeded with 1, 8, 95, 1183.
  function automatic bit [31:0] count_width5(input int unsigned len);
    bit [31:0] a0, a1, a2, a3, pos, neg, nx;
    int unsigned pairs;
    int unsigned step;
    a0    = 1;
    a1    = 8;
    a2    = 95;
    a3    = 1183;
    pairs = len >> 1;
    if (pairs == 1) begin
      return a1;
    end
    if (pairs == 2) begin
      return a2;
    end
    for (step = 4; step <= pairs; step++) begin
      pos = add_mod(scale_mod(a3, 15), scale_mod(a1, 15));
      neg = add_mod(scale_mod(a2, 32), a0);
      nx  = sub_mod(pos, neg);
      a0  = a1;
      a1  = a2;
      a2  = a3;
      a3  = nx;
    end
    return a3;
  endfunction

  function automatic logic [dtc_pkg::CntW-1:0] tilings_mod_prime(
    input logic [2:0] width, input logic [dtc_pkg::LenW-1:0] length);
    bit [31:0] r;
    bit        odd;
    odd = length[0];
    r   = 0;
    if (length != 0) begin
      case (width)
        3'd3: r = odd ? 32'd0 : count_width3(length);
        3'd4: r = count_width4(length);
        3'd5: r = odd ? 32'd0 : count_width5(length);
        default: r = 0;
      endcase
    end
    return r[dtc_pkg::CntW-1:0];
  endfunction

  // Output side first, so a result can never be matched with a board taken at the same edge.
  always @(posedge clk_i) begin
    board_answer_t due;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("Unexpected count %0d with no board outstanding", tiling_count_i);
          end
        end else begin
          due = answers_due.pop_front();
          pending--;
          checked++;
          if (tiling_count_i !== due.count) begin
            failures++;
            if (failures <= 10) begin
              $display("Count mismatch: width %0d length %0d expected %0d actual %0d",
                       due.width, due.length, due.count, tiling_count_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due.width  = board_width_i;
        due.length = board_length_i;
        due.count  = tilings_mod_prime(board_width_i, board_length_i);
        answers_due.push_back(due);
        pending++;
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Top of the domino tiling counter bench: clock, reset, board stimulus and output flow control.
// Depends on dtc_pkg, domino_tiling_counter_core and dtc_tiling_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 300;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [2:0]               board_width_i;
  logic [dtc_pkg::LenW-1:0] board_length_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [dtc_pkg::CntW-1:0] tiling_count_o;

  int failures;
  int pending;
  int checked;

  // Flow-control knobs. The receiver process reads rx_stall_pct and hold_ask, so they
  // are only ever changed with nonblocking assignments at a clock edge.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_ask     = 0;

  // Bookkeeping for the closing summary.
  int boards_by_width[8];
  int longest_board = 0;
  int random_index  = 0;

  domino_tiling_counter_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .board_width_i  (board_width_i),
    .board_length_i (board_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tiling_count_o (tiling_count_o)
  );

  dtc_tiling_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .board_width_i  (board_width_i),
    .board_length_i (board_length_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .tiling_count_i (tiling_count_o),
    .failures_o     (failures),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The slowest board is width 5 with 65534 columns. The stimulus holds at most six
  // boards that long, so this limit leaves room for every stall and gap on top of
  // a correct run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver. Each cycle it stalls with the current probability, except while a long
  // hold is running. A hold starts whenever the stimulus bumps hold_ask; the cycles are
  // counted here so that the sender keeps offering boards meanwhile and the block's
  // queue fills up until its input stalls as well.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Offers one board and returns at the edge where it is transferred. Idle cycles, if
  // any, come before the board, so valid is never dropped and raised in one time step,
  // and back-to-back boards keep valid high across the transfer edge.
  task automatic send_board(input logic [2:0] width, input logic [dtc_pkg::LenW-1:0] length);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    board_width_i  <= width;
    board_length_i <= length;
    boards_by_width[width]++;
    if (int'(length) > longest_board) begin
      longest_board = int'(length);
    end
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random boards. Most are short so the run stays quick; every tenth is medium sized
  // and three in the whole run take the full 16-bit length range, which is what
  // exercises the upper length bits. About one board in ten gets an arbitrary 3-bit
  // width, including the widths that the block answers with zero.
  task automatic random_boards(input int count);
    logic [2:0]               width;
    logic [dtc_pkg::LenW-1:0] length;
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        width = 3'($urandom_range(7));
      end else begin
        width = 3'($urandom_range(5, 3));
      end
      if (random_index % 25 == 16) begin
        length = 16'($urandom);
      end else if (random_index % 10 == 3) begin
        length = 16'($urandom_range(4095));
      end else begin
        length = 16'($urandom_range(200));
      end
      random_index++;
      send_board(width, length);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    board_width_i  = 3'd0;
    board_length_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed boards with no idling on either side. Width 3: odd area, the seed
    // length, a short run and both ends of the length range.
    send_board(3'd3, 16'd1);
    send_board(3'd3, 16'd2);
    send_board(3'd3, 16'd4);
    send_board(3'd3, 16'd12);
    send_board(3'd3, 16'd65534);
    send_board(3'd3, 16'd65535);
    // Width 4 has no odd-area case; length 1 and 2 are the seeds.
    send_board(3'd4, 16'd1);
    send_board(3'd4, 16'd2);
    send_board(3'd4, 16'd3);
    send_board(3'd4, 16'd65535);
    // Width 5 follows the known sequence 8, 95, 1183, 14824 for 2, 4, 6, 8 columns.
    send_board(3'd5, 16'd1);
    send_board(3'd5, 16'd2);
    send_board(3'd5, 16'd4);
    send_board(3'd5, 16'd6);
    send_board(3'd5, 16'd8);
    send_board(3'd5, 16'd10);
    send_board(3'd5, 16'd65534);
    // Zero length for each supported width, then the unsupported widths.
    send_board(3'd3, 16'd0);
    send_board(3'd4, 16'd0);
    send_board(3'd5, 16'd0);
    send_board(3'd0, 16'd40);
    send_board(3'd1, 16'h8000);
    send_board(3'd2, 16'd7);
    send_board(3'd6, 16'd100);
    send_board(3'd7, 16'd65535);
    random_boards(17);

    // Long output hold while short boards keep coming, so the queue fills and the
    // input side has to stall.
    hold_ask <= hold_ask + 1;
    for (int i = 0; i < 8; i++) begin
      send_board((i % 2 == 0) ? 3'd4 : 3'd3, 16'(2 + i));
    end

    // Sender idles most of the time.
    tx_idle_pct = 71;
    random_boards(17);

    // Receiver stalls most of the time.
    tx_idle_pct = 0;
    rx_stall_pct <= 71;
    random_boards(17);

    // Both sides idle about a third of the time.
    tx_idle_pct = 37;
    rx_stall_pct <= 37;
    random_boards(17);

    in_valid_i   <= 1'b0;
    rx_stall_pct <= 0;
    // One more edge so the checker has booked the last board before the drain wait.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Fixed answers skip the recurrence, so any stray result would show here.
    repeat (100) @(posedge clk_i);

    $display("Covered %0d boards: %0d of width 3, %0d of width 4, %0d of width 5, %0d other",
             boards_by_width.sum(), boards_by_width[3], boards_by_width[4],
             boards_by_width[5],
             boards_by_width.sum() - boards_by_width[3] - boards_by_width[4] -
             boards_by_width[5]);
    $display("Longest board %0d columns; %0d counts compared over four flow phases and a hold",
             longest_board, checked);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ domino_tiling_counter_core.f @@
rtl/core/dtc_pkg.sv
rtl/core/dtc_front.sv
rtl/core/dtc_queue.sv
rtl/core/dtc_back.sv
rtl/core/domino_tiling_counter_core.sv
bench/dtc_tiling_checker.sv
bench/tb.sv
